[hw/rtl/efom_pkg.sv]
// Shared types, constants and pointer helpers for the event queue.
package efom_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int HDR_W       = 8;
    localparam int TIME_W      = 32;
    localparam int VAL_W       = 32;
    localparam int STATUS_W    = 3;
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 1;

    // command queue between the front and back parts
    localparam int CQ_DEPTH    = 2;
    localparam int CQ_PTR_W    = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W    = $clog2(CQ_DEPTH + 1);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED   = 3'd0,
        ST_FILTERED = 3'd1,
        ST_MARKER   = 3'd2,
        ST_DROP     = 3'd3,
        ST_POP      = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RECORDING_ENABLE = 1'd0,
        REG_OVERFLOW_HEADER  = 1'd1
    } cfg_idx_t;

    typedef struct packed {
        logic [HDR_W-1:0]  hdr;
        logic [TIME_W-1:0] tstamp;
        logic [VAL_W-1:0]  value;
    } entry_t;

    // decoded command as the front part hands it over
    typedef struct packed {
        logic   is_pop;
        logic   keep;    // passes the recording filter
        entry_t entry;
    } cmd_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_LAST : p - PTR_W'(1);
    endfunction

endpackage

[hw/rtl/event_fifo_with_overflow_marker_top.sv]
// Top level of the event queue with overflow marker.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------
//  input     | in_valid / in_stall  | func, is_confirm, in_header, in_time, in_value
//  result    | res_valid/ res_stall | status, out_valid, out_header, out_time,
//            |                      | out_value
//  config    | cfg_we               | cfg_index, cfg_data
//
// One beat per cycle in both directions while the result side does not stall; a result
// leaves once its input beat has passed the command queue slot, then the result register.
// The registered memory read lands together with the result register.
// rst_n clears pointers, command queue and result register; the entry memory
// is not cleared (entries are always written before they are read).
// A stalled result holds the back part, the two-entry command queue then fills
// and in_stall rises; the input side never waits on the result side otherwise.
module event_fifo_with_overflow_marker_top
    import efom_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 func,
    input  logic                 is_confirm,
    input  logic [HDR_W-1:0]     in_header,
    input  logic [TIME_W-1:0]    in_time,
    input  logic [VAL_W-1:0]     in_value,
    // result channel
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic [STATUS_W-1:0]  status,
    output logic                 out_valid,
    output logic [HDR_W-1:0]     out_header,
    output logic [TIME_W-1:0]    out_time,
    output logic [VAL_W-1:0]     out_value
);

    // configuration registers; the user must write them only while the block is idle, the block does not enforce it
    logic             rec_en_reg;
    logic [HDR_W-1:0] ovf_hdr_reg;

    // front -> back command handoff
    logic             cmd_valid;
    logic             cmd_take;
    cmd_t             cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_en_reg  <= 1'b0;
            ovf_hdr_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_RECORDING_ENABLE: rec_en_reg  <= cfg_data[0];
                REG_OVERFLOW_HEADER:  ovf_hdr_reg <= cfg_data[HDR_W-1:0];
                default:              ;
            endcase
        end
    end

    // front: takes beats, applies the recording filter decision, queues commands
    efom_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .recording_enable (rec_en_reg),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .func             (func),
        .is_confirm       (is_confirm),
        .in_header        (in_header),
        .in_time          (in_time),
        .in_value         (in_value),
        .cmd_valid        (cmd_valid),
        .cmd              (cmd),
        .cmd_take         (cmd_take)
    );

    // back: room check, marker handling, memory access, result register
    efom_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .overflow_header (ovf_hdr_reg),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_take        (cmd_take),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .status          (status),
        .out_valid       (out_valid),
        .out_header      (out_header),
        .out_time        (out_time),
        .out_value       (out_value)
    );

endmodule

[hw/rtl/efom_front.sv]
// Front part: accepts input beats, decodes them and queues the commands.
module efom_front
    import efom_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              recording_enable,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              func,
    input  logic              is_confirm,
    input  logic [HDR_W-1:0]  in_header,
    input  logic [TIME_W-1:0] in_time,
    input  logic [VAL_W-1:0]  in_value,
    output logic              cmd_valid,
    output cmd_t              cmd,
    input  logic              cmd_take
);

    cmd_t                q_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                accept;
    cmd_t                dec;

    assign in_stall  = (cnt_reg == CQ_CNT_W'(CQ_DEPTH));
    assign accept    = in_valid && !in_stall;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        dec.is_pop       = func;
        dec.keep         = is_confirm | recording_enable;
        dec.entry.hdr    = in_header;
        dec.entry.tstamp = in_time;
        dec.entry.value  = in_value;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (accept)
        begin
            wr_ptr_next = (wr_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + CQ_PTR_W'(1);
        end
        if (cmd_take)
        begin
            rd_ptr_next = (rd_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + CQ_PTR_W'(1);
        end
        if (accept && !cmd_take)
        begin
            cnt_next = cnt_reg + CQ_CNT_W'(1);
        end
        else if (!accept && cmd_take)
        begin
            cnt_next = cnt_reg - CQ_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

[hw/rtl/efom_back.sv]
// Back part: pointers, entry memory, overflow marker and result register.
module efom_back
    import efom_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [HDR_W-1:0]    overflow_header,
    input  logic                cmd_valid,
    input  cmd_t                cmd,
    output logic                cmd_take,
    output logic                res_valid,
    input  logic                res_stall,
    output logic [STATUS_W-1:0] status,
    output logic                out_valid,
    output logic [HDR_W-1:0]    out_header,
    output logic [TIME_W-1:0]   out_time,
    output logic [VAL_W-1:0]    out_value
);

    entry_t            store_reg [QUEUE_DEPTH];
    entry_t            rd_data_reg;
    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [PTR_W-1:0]  wp_reg, wp_next;
    logic [VAL_W-1:0]  cnt_reg, cnt_next;      // count of the newest marker
    logic [HDR_W-1:0]  mark_hdr_reg, mark_hdr_next;
    logic              res_valid_reg, res_valid_next;
    status_t           res_status_reg, res_status_next;
    logic              res_hit_reg, res_hit_next;
    logic [PTR_W-1:0]  wp1, wp2;
    logic              mem_we, mem_re;
    logic [PTR_W-1:0]  mem_waddr;
    entry_t            mem_wdata;
    logic [VAL_W-1:0]  cnt_sat;

    assign cmd_take = cmd_valid && (!res_valid_reg || !res_stall);
    assign wp1      = ptr_inc(wp_reg);
    assign wp2      = ptr_inc(wp1);
    assign cnt_sat  = (&cnt_reg) ? cnt_reg : cnt_reg + VAL_W'(1);

    always_comb
    begin
        rp_next         = rp_reg;
        wp_next         = wp_reg;
        cnt_next        = cnt_reg;
        mark_hdr_next   = mark_hdr_reg;
        res_status_next = res_status_reg;
        res_hit_next    = res_hit_reg;
        res_valid_next  = res_valid_reg && res_stall;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = wp_reg;
        mem_wdata       = cmd.entry;
        if (cmd_take)
        begin
            res_valid_next = 1'b1;
            res_hit_next   = 1'b0;
            if (cmd.is_pop)
            begin
                res_status_next = ST_POP;
                if (rp_reg != wp_reg)
                begin
                    res_hit_next = 1'b1;
                    mem_re       = 1'b1;
                    rp_next      = ptr_inc(rp_reg);
                end
            end
            else if (rp_reg == wp2)
            begin
                // two slots left: marker replaces the push
                res_status_next  = ST_MARKER;
                mem_we           = 1'b1;
                mem_wdata.hdr    = overflow_header;
                mem_wdata.tstamp = '0;
                mem_wdata.value  = VAL_W'(1);
                mark_hdr_next    = overflow_header;
                cnt_next         = VAL_W'(1);
                wp_next          = wp1;
            end
            else if (rp_reg == wp1)
            begin
                // one slot left: newest entry is the marker, bump its count
                res_status_next  = ST_DROP;
                mem_we           = 1'b1;
                mem_waddr        = ptr_dec(wp_reg);
                mem_wdata.hdr    = mark_hdr_reg;
                mem_wdata.tstamp = '0;
                mem_wdata.value  = cnt_sat;
                cnt_next         = cnt_sat;
            end
            else if (cmd.keep)
            begin
                res_status_next = ST_STORED;
                mem_we          = 1'b1;
                wp_next         = wp1;
            end
            else
            begin
                res_status_next = ST_FILTERED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg         <= '0;
            wp_reg         <= '0;
            res_valid_reg  <= 1'b0;
            res_status_reg <= ST_STORED;
            res_hit_reg    <= 1'b0;
        end
        else
        begin
            rp_reg         <= rp_next;
            wp_reg         <= wp_next;
            res_valid_reg  <= res_valid_next;
            res_status_reg <= res_status_next;
            res_hit_reg    <= res_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        mark_hdr_reg <= mark_hdr_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_reg[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= store_reg[rp_reg];
        end
    end

    assign res_valid  = res_valid_reg;
    assign status     = res_status_reg;
    assign out_valid  = res_hit_reg;
    assign out_header = res_hit_reg ? rd_data_reg.hdr    : '0;
    assign out_time   = res_hit_reg ? rd_data_reg.tstamp : '0;
    assign out_value  = res_hit_reg ? rd_data_reg.value  : '0;

endmodule

[hw/rtl/efom_checker.sv]
// Port-level checks on the event queue, bound to the top level.
module efom_checker
    import efom_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic                res_stall,
    input logic [STATUS_W-1:0] status,
    input logic                out_valid,
    input logic [HDR_W-1:0]    out_header,
    input logic [TIME_W-1:0]   out_time,
    input logic [VAL_W-1:0]    out_value
);

    // stalled result beat holds its status, out_valid and out_value
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(status) && $stable(out_valid)
            && $stable(out_value))
        else $error("stalled result beat changed");

    // only a pop returns an entry
    a_hit_is_pop: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && out_valid |-> status == ST_POP)
        else $error("entry returned on a push result");

    // push results and empty pops carry zero data
    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !out_valid |-> out_header == '0 && out_time == '0 && out_value == '0)
        else $error("data on a result without entry");

    // status is one of the five result codes
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> status <= ST_POP)
        else $error("status code out of range");

endmodule

bind event_fifo_with_overflow_marker_top efom_checker u_efom_checker (.*);
